// ===== rtl/ewc_pkg.sv =====
// Shared widths, limits and types of the energy-weighted centroid block.
`timescale 1ns / 1ps
package ewc_pkg;

  localparam int EnergyW       = 24;
  localparam int PosW          = 20;
  localparam int LayerW        = 8;
  localparam int EsumW         = 36;
  localparam int WsumW         = 57;
  localparam int ProdW         = EnergyW + 1 + PosW;
  localparam int MaxHits       = 4096;
  localparam int LayerSentinel = 255;
  localparam int HitCntW       = $clog2(MaxHits + 1);
  localparam int QDepth        = 2;
  localparam int QPtrW         = $clog2(QDepth);
  localparam int QCntW         = $clog2(QDepth + 1);
  localparam int DivCntW       = $clog2(WsumW);
  localparam int Lanes         = 3;

  typedef struct packed {
    logic signed [WsumW-1:0] wx;
    logic signed [WsumW-1:0] wy;
    logic signed [WsumW-1:0] wz;
    logic [EsumW-1:0]        energy;
    logic [LayerW-1:0]       width;
    logic                    ovf;
    logic signed [PosW-1:0]  sx;
    logic signed [PosW-1:0]  sy;
    logic signed [PosW-1:0]  sz;
  } cluster_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/ewc_front.sv =====
// Front end: hit products and per-cluster accumulation of energy, weighted sums and layers.
`timescale 1ns / 1ps
module ewc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ewc_pkg::EnergyW-1:0]    hit_energy_i,
  input  logic signed [ewc_pkg::PosW-1:0] hit_x_i,
  input  logic signed [ewc_pkg::PosW-1:0] hit_y_i,
  input  logic signed [ewc_pkg::PosW-1:0] hit_z_i,
  input  logic [ewc_pkg::LayerW-1:0]     hit_layer_i,
  input  logic signed [ewc_pkg::PosW-1:0] seed_x_i,
  input  logic signed [ewc_pkg::PosW-1:0] seed_y_i,
  input  logic signed [ewc_pkg::PosW-1:0] seed_z_i,
  input  logic                           last_hit_i,
  input  ewc_pkg::fifo_stat_t            q_stat_i,
  output logic                           push_o,
  output ewc_pkg::cluster_t              rec_o
);

  logic adv;
  logic step;
  logic take;

  logic signed [ewc_pkg::ProdW-1:0] px_d, py_d, pz_d;
  logic signed [ewc_pkg::ProdW-1:0] a_px_q, a_py_q, a_pz_q;
  logic [ewc_pkg::EnergyW-1:0]      a_e_q;
  logic [ewc_pkg::LayerW-1:0]       a_layer_q;
  logic signed [ewc_pkg::PosW-1:0]  a_sx_q, a_sy_q, a_sz_q;
  logic                             a_last_q;
  logic                             a_valid_q, a_valid_d;

  logic [ewc_pkg::EsumW-1:0]        esum_q, esum_new;
  logic [ewc_pkg::EsumW:0]          esum_add;
  logic signed [ewc_pkg::WsumW-1:0] wx_q, wy_q, wz_q, wx_new, wy_new, wz_new;
  logic [ewc_pkg::LayerW-1:0]       lo_q, hi_q, lo_new, hi_new;
  logic [ewc_pkg::HitCntW-1:0]      cnt_q, cnt_new;
  logic                             ovf_q, ovf_new;
  logic                             cap;
  logic                             first;

  assign adv        = !q_stat_i.full;
  assign in_stall_o = q_stat_i.full;
  assign take       = adv && in_valid_i;
  assign step       = adv && a_valid_q;

  assign px_d = $signed({1'b0, hit_energy_i}) * hit_x_i;
  assign py_d = $signed({1'b0, hit_energy_i}) * hit_y_i;
  assign pz_d = $signed({1'b0, hit_energy_i}) * hit_z_i;

  assign a_valid_d = adv ? in_valid_i : a_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_px_q    <= px_d;
      a_py_q    <= py_d;
      a_pz_q    <= pz_d;
      a_e_q     <= hit_energy_i;
      a_layer_q <= hit_layer_i;
      a_sx_q    <= seed_x_i;
      a_sy_q    <= seed_y_i;
      a_sz_q    <= seed_z_i;
      a_last_q  <= last_hit_i;
    end
  end

  always_comb begin
    cap      = cnt_q < ewc_pkg::HitCntW'(ewc_pkg::MaxHits);
    first    = cnt_q == '0;
    esum_add = {1'b0, esum_q}
             + {{(ewc_pkg::EsumW + 1 - ewc_pkg::EnergyW){1'b0}}, a_e_q};
    esum_new = esum_q;
    wx_new   = wx_q;
    wy_new   = wy_q;
    wz_new   = wz_q;
    lo_new   = lo_q;
    hi_new   = hi_q;
    cnt_new  = cnt_q;
    if (cap) begin
      esum_new = esum_add[ewc_pkg::EsumW] ? '1 : esum_add[ewc_pkg::EsumW-1:0];
      wx_new   = wx_q + {{(ewc_pkg::WsumW - ewc_pkg::ProdW){a_px_q[ewc_pkg::ProdW-1]}}, a_px_q};
      wy_new   = wy_q + {{(ewc_pkg::WsumW - ewc_pkg::ProdW){a_py_q[ewc_pkg::ProdW-1]}}, a_py_q};
      wz_new   = wz_q + {{(ewc_pkg::WsumW - ewc_pkg::ProdW){a_pz_q[ewc_pkg::ProdW-1]}}, a_pz_q};
      if (first || a_layer_q < lo_q) begin
        lo_new = a_layer_q;
      end
      if (first || a_layer_q > hi_q) begin
        hi_new = a_layer_q;
      end
      cnt_new = cnt_q + ewc_pkg::HitCntW'(1);
    end
    ovf_new = ovf_q | !cap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      wx_q   <= '0;
      wy_q   <= '0;
      wz_q   <= '0;
      lo_q   <= ewc_pkg::LayerW'(ewc_pkg::LayerSentinel);
      hi_q   <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (step) begin
      if (a_last_q) begin
        esum_q <= '0;
        wx_q   <= '0;
        wy_q   <= '0;
        wz_q   <= '0;
        lo_q   <= ewc_pkg::LayerW'(ewc_pkg::LayerSentinel);
        hi_q   <= '0;
        cnt_q  <= '0;
        ovf_q  <= 1'b0;
      end else begin
        esum_q <= esum_new;
        wx_q   <= wx_new;
        wy_q   <= wy_new;
        wz_q   <= wz_new;
        lo_q   <= lo_new;
        hi_q   <= hi_new;
        cnt_q  <= cnt_new;
        ovf_q  <= ovf_new;
      end
    end
  end

  assign push_o       = step && a_last_q;
  assign rec_o.wx     = wx_new;
  assign rec_o.wy     = wy_new;
  assign rec_o.wz     = wz_new;
  assign rec_o.energy = esum_new;
  assign rec_o.width  = hi_new - lo_new;
  assign rec_o.ovf    = ovf_new;
  assign rec_o.sx     = a_sx_q;
  assign rec_o.sy     = a_sy_q;
  assign rec_o.sz     = a_sz_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ewc_pkg::HitCntW'(ewc_pkg::MaxHits))
    else $error("hit count beyond limit");
`endif

endmodule

// ===== rtl/ewc_queue.sv =====
// Two-entry queue of finished cluster sums between front and back.
`timescale 1ns / 1ps
module ewc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ewc_pkg::cluster_t   data_i,
  input  logic                pop_i,
  output ewc_pkg::cluster_t   data_o,
  output ewc_pkg::fifo_stat_t stat_o
);

  ewc_pkg::cluster_t              mem_q [ewc_pkg::QDepth];
  logic [ewc_pkg::QPtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [ewc_pkg::QCntW-1:0]      cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == ewc_pkg::QPtrW'(ewc_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == ewc_pkg::QPtrW'(ewc_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = cnt_q == ewc_pkg::QCntW'(ewc_pkg::QDepth);
  assign stat_o.empty = cnt_q == '0;

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");
`endif

endmodule

// ===== rtl/ewc_back.sv =====
// Back end: three restoring dividers, centroid saturation and the result register.
`timescale 1ns / 1ps
module ewc_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ewc_pkg::fifo_stat_t              q_stat_i,
  input  ewc_pkg::cluster_t                rec_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [ewc_pkg::PosW-1:0]  centroid_x_o,
  output logic signed [ewc_pkg::PosW-1:0]  centroid_y_o,
  output logic signed [ewc_pkg::PosW-1:0]  centroid_z_o,
  output logic [ewc_pkg::EsumW-1:0]        total_energy_o,
  output logic [ewc_pkg::LayerW-1:0]       layer_width_o,
  output logic                             used_seed_o,
  output logic                             hit_overflow_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } back_state_e;

  typedef struct packed {
    logic [ewc_pkg::EsumW-1:0] rem;
    logic [ewc_pkg::WsumW-1:0] dq;
  } div_t;

  function automatic div_t div_step(input logic [ewc_pkg::EsumW-1:0] rem,
                                    input logic [ewc_pkg::WsumW-1:0] dq,
                                    input logic [ewc_pkg::EsumW-1:0] dvs);
    logic [ewc_pkg::EsumW:0] t;
    logic [ewc_pkg::EsumW:0] s;
    logic                    ge;
    div_t                    r;
    t  = {rem, dq[ewc_pkg::WsumW-1]};
    s  = t - {1'b0, dvs};
    ge = t >= {1'b0, dvs};
    r.rem = ge ? s[ewc_pkg::EsumW-1:0] : t[ewc_pkg::EsumW-1:0];
    r.dq  = {dq[ewc_pkg::WsumW-2:0], ge};
    return r;
  endfunction

  function automatic logic [ewc_pkg::PosW-1:0] sat_quot(
      input logic [ewc_pkg::WsumW-1:0] q, input logic neg);
    logic [ewc_pkg::WsumW-1:0] lim;
    logic [ewc_pkg::WsumW-1:0] m;
    lim = neg ? ewc_pkg::WsumW'(1) << (ewc_pkg::PosW - 1)
              : (ewc_pkg::WsumW'(1) << (ewc_pkg::PosW - 1)) - 1'b1;
    m   = (q > lim) ? lim : q;
    m   = neg ? ('0 - m) : m;
    return m[ewc_pkg::PosW-1:0];
  endfunction

  back_state_e                      state_q, state_d;
  logic [ewc_pkg::DivCntW-1:0]      cnt_q, cnt_d;

  logic [ewc_pkg::EsumW-1:0]        dvs_q;
  logic [ewc_pkg::EsumW-1:0]        rem_q [ewc_pkg::Lanes];
  logic [ewc_pkg::WsumW-1:0]        dq_q  [ewc_pkg::Lanes];
  logic                             neg_q [ewc_pkg::Lanes];
  logic signed [ewc_pkg::PosW-1:0]  seed_q [ewc_pkg::Lanes];
  logic [ewc_pkg::LayerW-1:0]       width_q;
  logic                             ovf_q;
  logic                             used_q;

  logic signed [ewc_pkg::WsumW-1:0] ws [ewc_pkg::Lanes];
  logic signed [ewc_pkg::PosW-1:0]  sd [ewc_pkg::Lanes];
  div_t                             nx [ewc_pkg::Lanes];
  logic [ewc_pkg::PosW-1:0]         res [ewc_pkg::Lanes];

  logic signed [ewc_pkg::PosW-1:0]  out_c_q [ewc_pkg::Lanes];
  logic [ewc_pkg::EsumW-1:0]        out_e_q;
  logic [ewc_pkg::LayerW-1:0]       out_w_q;
  logic                             out_used_q;
  logic                             out_ovf_q;
  logic                             out_valid_q, out_valid_d;
  logic                             load_out;
  logic                             zero_e;

  assign ws[0] = rec_i.wx;
  assign ws[1] = rec_i.wy;
  assign ws[2] = rec_i.wz;
  assign sd[0] = rec_i.sx;
  assign sd[1] = rec_i.sy;
  assign sd[2] = rec_i.sz;

  assign pop_o    = (state_q == S_IDLE) && !q_stat_i.empty;
  assign zero_e   = rec_i.energy == '0;
  assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    for (int i = 0; i < ewc_pkg::Lanes; i++) begin
      nx[i]  = div_step(rem_q[i], dq_q[i], dvs_q);
      res[i] = used_q ? seed_q[i] : sat_quot(dq_q[i], neg_q[i]);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (pop_o) begin
          state_d = zero_e ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ewc_pkg::DivCntW'(ewc_pkg::WsumW - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dvs_q   <= rec_i.energy;
      width_q <= rec_i.width;
      ovf_q   <= rec_i.ovf;
      used_q  <= zero_e;
      for (int i = 0; i < ewc_pkg::Lanes; i++) begin
        rem_q[i]  <= '0;
        neg_q[i]  <= ws[i][ewc_pkg::WsumW-1];
        dq_q[i]   <= ws[i][ewc_pkg::WsumW-1] ? ('0 - ws[i]) : ws[i];
        seed_q[i] <= sd[i];
      end
    end else if (state_q == S_DIV) begin
      for (int i = 0; i < ewc_pkg::Lanes; i++) begin
        rem_q[i] <= nx[i].rem;
        dq_q[i]  <= nx[i].dq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int i = 0; i < ewc_pkg::Lanes; i++) begin
        out_c_q[i] <= res[i];
      end
      out_e_q    <= dvs_q;
      out_w_q    <= width_q;
      out_used_q <= used_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign centroid_x_o   = out_c_q[0];
  assign centroid_y_o   = out_c_q[1];
  assign centroid_z_o   = out_c_q[2];
  assign total_energy_o = out_e_q;
  assign layer_width_o  = out_w_q;
  assign used_seed_o    = out_used_q;
  assign hit_overflow_o = out_ovf_q;

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> dvs_q != '0)
    else $error("divide started with zero energy");
  a_seed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_used_q |-> out_e_q == '0)
    else $error("seed emitted with nonzero energy");
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result raised outside finish state");
`endif

endmodule

// ===== rtl/energy_weighted_centroid.sv =====
// Top level of the energy-weighted cluster centroid block.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    hit_*, seed_*, last_hit_i
//   out      output     out_valid_o / out_stall_i  centroid_*, total_energy_o,
//                                                   layer_width_o, used_seed_o,
//                                                   hit_overflow_o
//
// Hits are taken one beat per cycle while in_stall_o is low; each is registered, then summed.
// Each cluster result takes 57 restoring divide steps in the back end, or none with the seed.
// A two-entry cluster queue decouples the two halves; in_stall_o is high while it is full.
// out_stall_i holds the result register; the back end parks its next result until it frees.
// Reset clears the cluster sums, the queue and the result valid.
`timescale 1ns / 1ps
module energy_weighted_centroid (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ewc_pkg::EnergyW-1:0]      hit_energy_i,
  input  logic signed [ewc_pkg::PosW-1:0]  hit_x_i,
  input  logic signed [ewc_pkg::PosW-1:0]  hit_y_i,
  input  logic signed [ewc_pkg::PosW-1:0]  hit_z_i,
  input  logic [ewc_pkg::LayerW-1:0]       hit_layer_i,
  input  logic signed [ewc_pkg::PosW-1:0]  seed_x_i,
  input  logic signed [ewc_pkg::PosW-1:0]  seed_y_i,
  input  logic signed [ewc_pkg::PosW-1:0]  seed_z_i,
  input  logic                             last_hit_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [ewc_pkg::PosW-1:0]  centroid_x_o,
  output logic signed [ewc_pkg::PosW-1:0]  centroid_y_o,
  output logic signed [ewc_pkg::PosW-1:0]  centroid_z_o,
  output logic [ewc_pkg::EsumW-1:0]        total_energy_o,
  output logic [ewc_pkg::LayerW-1:0]       layer_width_o,
  output logic                             used_seed_o,
  output logic                             hit_overflow_o
);

  ewc_pkg::fifo_stat_t q_stat;
  ewc_pkg::cluster_t   push_rec;
  ewc_pkg::cluster_t   head_rec;
  logic                push;
  logic                pop;

  ewc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hit_energy_i (hit_energy_i),
    .hit_x_i      (hit_x_i),
    .hit_y_i      (hit_y_i),
    .hit_z_i      (hit_z_i),
    .hit_layer_i  (hit_layer_i),
    .seed_x_i     (seed_x_i),
    .seed_y_i     (seed_y_i),
    .seed_z_i     (seed_z_i),
    .last_hit_i   (last_hit_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  ewc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_rec),
    .pop_i  (pop),
    .data_o (head_rec),
    .stat_o (q_stat)
  );

  ewc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .rec_i          (head_rec),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .centroid_x_o   (centroid_x_o),
    .centroid_y_o   (centroid_y_o),
    .centroid_z_o   (centroid_z_o),
    .total_energy_o (total_energy_o),
    .layer_width_o  (layer_width_o),
    .used_seed_o    (used_seed_o),
    .hit_overflow_o (hit_overflow_o)
  );

endmodule
